// File: hw/rtl/limit_order_book_matcher_assert.svh
// Assertion macros for the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`ifndef SYNTH
`define LOBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("order book assertion failed");
`define LOBM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("order book forbidden condition");
`else
`define LOBM_ASSERT(lbl, prop)
`define LOBM_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/lobm_pkg.sv
// Shared types and constants of the order book matcher.
`default_nettype none
package lobm_pkg;
  localparam int unsigned DEF_PRICE_LEVELS     = 256;
  localparam int unsigned DEF_ORDERS_PER_LEVEL = 16;
  localparam int unsigned DEF_QTY_BITS         = 20;
  localparam int unsigned PRICE_W   = 8;
  localparam int unsigned IN_QTY_W  = 20;
  localparam int unsigned OUT_QTY_W = 20;

  localparam logic SIDE_BID      = 1'b0;
  localparam logic SIDE_ASK      = 1'b1;
  localparam logic ORDER_SELL    = 1'b1;
  localparam logic KIND_MARKET   = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic                sell;
    logic                market;
    logic [PRICE_W-1:0]  price;
    logic [IN_QTY_W-1:0] qty;
    logic                is_zero;
  } cmd_t;

  typedef struct packed {
    logic [OUT_QTY_W-1:0] filled;
    logic [OUT_QTY_W-1:0] rested;
    logic [OUT_QTY_W-1:0] dropped;
    logic                 status;
  } res_t;
endpackage
`default_nettype wire

// File: hw/rtl/lobm_fifo.sv
// Two-entry queue used between the matcher stages.
`default_nettype none
module lobm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end
endmodule
`default_nettype wire

// File: hw/rtl/lobm_front.sv
// Order intake: classifies each order and queues it for the engine.
`default_nettype none
module lobm_front import lobm_pkg::*; #(
  parameter int unsigned QTY_BITS = DEF_QTY_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic                side_i,
  input  wire logic                order_kind_i,
  input  wire logic [PRICE_W-1:0]  price_i,
  input  wire logic [IN_QTY_W-1:0] quantity_i,
  input  wire logic                block_i,
  output logic                     full_o,
  output cmd_t                     cmd_o,
  output logic                     cmd_valid_o,
  input  wire logic                cmd_pop_i
);
  cmd_t              cmd_in;
  logic [QTY_BITS-1:0] qty_used;
  logic              q_full, q_empty;
  logic [$bits(cmd_t)-1:0] q_out;

  // Only the low QTY_BITS bits of the quantity count.
  assign qty_used        = QTY_BITS'(quantity_i);
  assign cmd_in.sell     = side_i;
  assign cmd_in.market   = order_kind_i;
  assign cmd_in.price    = price_i;
  assign cmd_in.qty      = quantity_i;
  assign cmd_in.is_zero  = (qty_used == '0);

  assign full_o      = q_full || block_i;
  assign cmd_valid_o = !q_empty;
  assign cmd_o       = cmd_t'(q_out);

  lobm_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !full_o),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop_i),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );
endmodule
`default_nettype wire

// File: hw/rtl/lobm_engine.sv
// Matching engine: sweeps the opposite book side and rests remainders.
`default_nettype none
module lobm_engine import lobm_pkg::*; #(
  parameter int unsigned PRICE_LEVELS     = DEF_PRICE_LEVELS,
  parameter int unsigned ORDERS_PER_LEVEL = DEF_ORDERS_PER_LEVEL,
  parameter int unsigned QTY_BITS         = DEF_QTY_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  output res_t      res_o,
  output logic      res_push_o,
  input  wire logic res_full_i,
  output logic      clearing_o
);
  `include "limit_order_book_matcher_assert.svh"

  localparam int unsigned LW   = $clog2(PRICE_LEVELS);
  localparam int unsigned HW   = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
  localparam int unsigned CW   = $clog2(ORDERS_PER_LEVEL + 1);
  localparam int unsigned LE_W = HW + CW;
  localparam int unsigned LA_W = LW + 1;
  localparam int unsigned QA_W = LW + HW + 1;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_LVL  = 4'd3;
  localparam logic [3:0] ST_QRD  = 4'd4;
  localparam logic [3:0] ST_SCN  = 4'd5;
  localparam logic [3:0] ST_SCNC = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_RCK  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [LA_W-1:0]     clr_q, clr_d;
  logic                bid_vld_q, bid_vld_d, ask_vld_q, ask_vld_d;
  logic [LW-1:0]       bid_idx_q, bid_idx_d, ask_idx_q, ask_idx_d;
  logic [LW-1:0]       scan_q, scan_d;
  logic                sell_q, sell_d, market_q, market_d;
  logic [PRICE_W-1:0]  price_q, price_d;
  logic [QTY_BITS-1:0] qty_q, qty_d, rem_q, rem_d, filled_q, filled_d;
  logic [QTY_BITS-1:0] rested_q, rested_d, dropped_q, dropped_d;
  logic                status_q, status_d;
  logic [HW-1:0]       cur_head_q, cur_head_d;
  logic [CW-1:0]       cur_cnt_q, cur_cnt_d;

  logic [LE_W-1:0]     lvl_mem [2**LA_W];
  logic [QTY_BITS-1:0] qty_mem [2**QA_W];
  logic [LE_W-1:0]     lvl_rd_q;
  logic [QTY_BITS-1:0] qty_rd_q;
  logic [LA_W-1:0]     lr_addr, lw_addr;
  logic [LE_W-1:0]     lw_data;
  logic                lw_en;
  logic [QA_W-1:0]     qr_addr, qw_addr;
  logic [QTY_BITS-1:0] qw_data;
  logic                qw_en;

  logic                opp, own, best_vld, own_vld, limit_fail, in_ladder, own_better;
  logic [LW-1:0]       best_idx, own_idx, price_lvl;
  logic [HW-1:0]       lr_head, nxt_head;
  logic [CW-1:0]       lr_cnt, nxt_cnt;
  logic [QTY_BITS-1:0] take, new_avail;
  logic [CW:0]         pos_sum;
  logic [HW-1:0]       pos;

  assign opp       = sell_q ? SIDE_BID : SIDE_ASK;
  assign own       = sell_q ? SIDE_ASK : SIDE_BID;
  assign best_vld  = (opp == SIDE_BID) ? bid_vld_q : ask_vld_q;
  assign best_idx  = (opp == SIDE_BID) ? bid_idx_q : ask_idx_q;
  assign own_vld   = (own == SIDE_BID) ? bid_vld_q : ask_vld_q;
  assign own_idx   = (own == SIDE_BID) ? bid_idx_q : ask_idx_q;
  assign price_lvl = LW'(price_q);
  assign in_ladder = 32'(price_q) < 32'(PRICE_LEVELS);
  assign limit_fail = (opp == SIDE_ASK) ? (32'(best_idx) > 32'(price_q))
                                        : (32'(best_idx) < 32'(price_q));
  assign own_better = !own_vld ||
                      ((own == SIDE_BID) ? (32'(price_q) > 32'(own_idx))
                                         : (32'(price_q) < 32'(own_idx)));
  assign lr_head   = lvl_rd_q[LE_W-1:CW];
  assign lr_cnt    = lvl_rd_q[CW-1:0];
  assign take      = (qty_rd_q < rem_q) ? qty_rd_q : rem_q;
  assign new_avail = qty_rd_q - take;
  assign nxt_head  = (new_avail != '0) ? cur_head_q :
                     (cur_head_q == HW'(ORDERS_PER_LEVEL - 1)) ? '0 : cur_head_q + 1'b1;
  assign nxt_cnt   = (new_avail == '0) ? cur_cnt_q - 1'b1 : cur_cnt_q;
  assign pos_sum   = (CW+1)'(lr_head) + (CW+1)'(lr_cnt);
  assign pos       = (pos_sum >= (CW+1)'(ORDERS_PER_LEVEL))
                     ? HW'(pos_sum - (CW+1)'(ORDERS_PER_LEVEL)) : HW'(pos_sum);

  assign clearing_o = (state_q == ST_CLR);
  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_push_o = (state_q == ST_DONE) && !res_full_i;
  assign res_o.filled  = OUT_QTY_W'(filled_q);
  assign res_o.rested  = OUT_QTY_W'(rested_q);
  assign res_o.dropped = OUT_QTY_W'(dropped_q);
  assign res_o.status  = status_q;

  always_comb begin
    state_d = state_q; clr_d = clr_q; scan_d = scan_q;
    bid_vld_d = bid_vld_q; bid_idx_d = bid_idx_q;
    ask_vld_d = ask_vld_q; ask_idx_d = ask_idx_q;
    sell_d = sell_q; market_d = market_q; price_d = price_q; qty_d = qty_q;
    rem_d = rem_q; filled_d = filled_q; rested_d = rested_q;
    dropped_d = dropped_q; status_d = status_q;
    cur_head_d = cur_head_q; cur_cnt_d = cur_cnt_q;
    lr_addr = '0; lw_addr = '0; lw_data = '0; lw_en = 1'b0;
    qr_addr = '0; qw_addr = '0; qw_data = '0; qw_en = 1'b0;
    case (state_q)
      ST_CLR: begin
        lw_en   = 1'b1;
        lw_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          sell_d    = (cmd_i.sell == ORDER_SELL);
          market_d  = (cmd_i.market == KIND_MARKET);
          price_d   = cmd_i.price;
          qty_d     = QTY_BITS'(cmd_i.qty);
          rem_d     = QTY_BITS'(cmd_i.qty);
          filled_d  = '0;
          rested_d  = '0;
          dropped_d = '0;
          status_d  = STATUS_OK;
          state_d   = cmd_i.is_zero ? ST_DONE : ST_CHK;
        end
      end
      ST_CHK: begin
        lr_addr = {opp, best_idx};
        if (rem_q == '0 || !best_vld || (!market_q && limit_fail)) state_d = ST_FIN;
        else state_d = ST_LVL;
      end
      ST_LVL: begin
        qr_addr    = {opp, best_idx, lr_head};
        cur_head_d = lr_head;
        cur_cnt_d  = lr_cnt;
        state_d    = ST_QRD;
      end
      ST_QRD: begin
        rem_d    = rem_q - take;
        filled_d = filled_q + take;
        qw_en    = 1'b1;
        qw_addr  = {opp, best_idx, cur_head_q};
        qw_data  = new_avail;
        lw_en    = 1'b1;
        lw_addr  = {opp, best_idx};
        lw_data  = (nxt_cnt == '0) ? '0 : {nxt_head, nxt_cnt};
        state_d  = ST_CHK;
        // Level emptied: find the next best level on this side.
        if (nxt_cnt == '0) begin
          if (opp == SIDE_ASK) begin
            if (best_idx == LW'(PRICE_LEVELS - 1)) ask_vld_d = 1'b0;
            else begin
              scan_d  = best_idx + 1'b1;
              state_d = ST_SCN;
            end
          end else begin
            if (best_idx == '0) bid_vld_d = 1'b0;
            else begin
              scan_d  = best_idx - 1'b1;
              state_d = ST_SCN;
            end
          end
        end
      end
      ST_SCN: begin
        lr_addr = {opp, scan_q};
        state_d = ST_SCNC;
      end
      ST_SCNC: begin
        if (lr_cnt != '0) begin
          if (opp == SIDE_ASK) ask_idx_d = scan_q;
          else bid_idx_d = scan_q;
          state_d = ST_CHK;
        end else if (opp == SIDE_ASK) begin
          if (scan_q == LW'(PRICE_LEVELS - 1)) begin
            ask_vld_d = 1'b0;
            state_d   = ST_CHK;
          end else begin
            scan_d  = scan_q + 1'b1;
            state_d = ST_SCN;
          end
        end else begin
          if (scan_q == '0) begin
            bid_vld_d = 1'b0;
            state_d   = ST_CHK;
          end else begin
            scan_d  = scan_q - 1'b1;
            state_d = ST_SCN;
          end
        end
      end
      ST_FIN: begin
        lr_addr = {own, price_lvl};
        if (rem_q == '0) state_d = ST_DONE;
        else if (market_q) begin
          dropped_d = rem_q;
          state_d   = ST_DONE;
        end else if (!in_ladder) begin
          dropped_d = rem_q;
          status_d  = STATUS_REJECT;
          state_d   = ST_DONE;
        end else state_d = ST_RCK;
      end
      ST_RCK: begin
        state_d = ST_DONE;
        if (lr_cnt >= CW'(ORDERS_PER_LEVEL)) begin
          dropped_d = rem_q;
          status_d  = STATUS_REJECT;
        end else begin
          rested_d = rem_q;
          qw_en    = 1'b1;
          qw_addr  = {own, price_lvl, pos};
          qw_data  = rem_q;
          lw_en    = 1'b1;
          lw_addr  = {own, price_lvl};
          lw_data  = {lr_head, lr_cnt + 1'b1};
          if (own_better) begin
            if (own == SIDE_BID) begin
              bid_vld_d = 1'b1;
              bid_idx_d = price_lvl;
            end else begin
              ask_vld_d = 1'b1;
              ask_idx_d = price_lvl;
            end
          end
        end
      end
      ST_DONE: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_q     <= '0;
      bid_vld_q <= 1'b0;
      ask_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      bid_vld_q <= bid_vld_d;
      ask_vld_q <= ask_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bid_idx_q <= bid_idx_d; ask_idx_q <= ask_idx_d; scan_q <= scan_d;
    sell_q <= sell_d; market_q <= market_d; price_q <= price_d; qty_q <= qty_d;
    rem_q <= rem_d; filled_q <= filled_d; rested_q <= rested_d;
    dropped_q <= dropped_d; status_q <= status_d;
    cur_head_q <= cur_head_d; cur_cnt_q <= cur_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) lvl_mem[lw_addr] <= lw_data;
    lvl_rd_q <= lvl_mem[lr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (qw_en) qty_mem[qw_addr] <= qw_data;
    qty_rd_q <= qty_mem[qr_addr];
  end

  `LOBM_ASSERT(a_qty_split, (state_q != ST_IDLE && state_q != ST_CLR) |-> (filled_q + rem_q == qty_q))
  `LOBM_NEVER(a_no_pop_in_clear, (state_q == ST_CLR) && cmd_pop_o)
  `LOBM_ASSERT(a_rest_nonzero, (state_q == ST_RCK) |-> (rem_q != '0))
endmodule
`default_nettype wire

// File: hw/rtl/limit_order_book_matcher.sv
// Top level of the price-time priority order matching engine.
// Usage: orders enter through a queue-like port (push/full); one result per
// order leaves through a queue-like port (empty/pop), oldest first.
// Each order is matched against the opposite side, best price first and
// oldest resting order first within a level; a limit remainder rests at its
// price, a market remainder is dropped, a remainder that finds its level
// full (or a price off the ladder) is dropped with status set.
// Flow: each order checks the best opposite level; for each resting order it
// touches, the level entry and the order's quantity are read and written back;
// after a level empties, the best-level search steps over empty levels; then
// the remainder rests or is dropped. The level and quantity memories take one
// access per cycle each. The engine takes one order at a time.
// Reset: the book is emptied by a pass over all 2*2^clog2(PRICE_LEVELS)
// entries of the level table (512 by default); full stays high meanwhile.
// A stalled result port (pop low) holds up to two results, after which the
// engine waits and the two-entry order queue fills and raises full.
`default_nettype none
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int unsigned PRICE_LEVELS     = DEF_PRICE_LEVELS,
  parameter int unsigned ORDERS_PER_LEVEL = DEF_ORDERS_PER_LEVEL,
  parameter int unsigned QTY_BITS         = DEF_QTY_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 side_i,
  input  wire logic                 order_kind_i,
  input  wire logic [PRICE_W-1:0]   price_i,
  input  wire logic [IN_QTY_W-1:0]  quantity_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic      [OUT_QTY_W-1:0] filled_quantity_o,
  output logic      [OUT_QTY_W-1:0] rested_quantity_o,
  output logic      [OUT_QTY_W-1:0] dropped_quantity_o,
  output logic                      status_o
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop, clearing, res_push, res_full;
  res_t res_in, res_out;
  logic [$bits(res_t)-1:0] res_bits;

  lobm_front #(.QTY_BITS(QTY_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .side_i       (side_i),
    .order_kind_i (order_kind_i),
    .price_i      (price_i),
    .quantity_i   (quantity_i),
    .block_i      (clearing),
    .full_o       (full),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  lobm_engine #(
    .PRICE_LEVELS     (PRICE_LEVELS),
    .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL),
    .QTY_BITS         (QTY_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .clearing_o  (clearing)
  );

  lobm_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_bits),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign res_out            = res_t'(res_bits);
  assign filled_quantity_o  = res_out.filled;
  assign rested_quantity_o  = res_out.rested;
  assign dropped_quantity_o = res_out.dropped;
  assign status_o           = res_out.status;
endmodule
`default_nettype wire
